// ===== hdl/sdlr_pkg.sv =====
// sdlr_pkg: shared widths, register indexes, status codes and pixel packing
// for the stereo SSD disparity block. No dependencies.
`timescale 1ns / 1ps

package sdlr_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 9;   // intensity in 7..0, pure-blue mark in 8
  localparam int IMG_DIM_W  = 11;
  localparam int COORD_W    = 10;
  localparam int DISP_W     = 6;
  localparam int WIN_W      = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int SQ_W       = 16;
  localparam int SUM_W      = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH    = 3'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT   = 3'd1;
  localparam cfg_idx_t CFG_DISPARITY_LOW  = 3'd2;
  localparam cfg_idx_t CFG_DISPARITY_HIGH = 3'd3;
  localparam cfg_idx_t CFG_WINDOW_SIZE    = 3'd4;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_VALID = 2'd0;
  localparam status_t ST_BLACK = 2'd1;
  localparam status_t ST_BLUE  = 2'd2;
  localparam status_t ST_SKIP  = 2'd3;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  function automatic logic [PIX_W-1:0] pack_pixel(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] m;
    logic              mark;
    m = r;
    if (g > m) m = g;
    if (b > m) m = b;
    mark = (r == '0) && (g == '0) && (b == CHAN_MAX);
    return {mark, m};
  endfunction

endpackage

// ===== hdl/stereo_ssd_disparity_lr_check.sv =====
// Stereo SSD block matcher with left-right consistency check.
// Depends on sdlr_pkg (widths, codes, pixel packing).
`timescale 1ns / 1ps
//
//  channel  direction  signals                                    beat when
//  in       sink       in_valid/in_stall, kind, row, col, rgb x2  in_valid & !in_stall
//  out      source     out_valid/out_stall, status, disparity,    out_valid & !out_stall
//                      gray
//  cfg      sink       cfg_we, cfg_index, cfg_data                cfg_we
//
// A load beat inside the image is written to both image memories in its accept cycle.
// A compute beat walks one window tap per cycle through a single square-and-add
// unit for each disparity tried, over (hi-lo+1) forward and
// (d1+4-lo) backward disparities, then checks and divides 255 by (hi-lo) for
// the gray scale factor. in_stall is high for the whole of a compute item.
// rst is synchronous; the image memories are not cleared. The finished result
// waits in the output register while out_stall is high.

module stereo_ssd_disparity_lr_check import sdlr_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_WINDOW    = 15,
  parameter int MAX_DISPARITY = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [COORD_W-1:0]    row,
  input  logic [COORD_W-1:0]    col,
  input  logic [CHAN_W-1:0]     left_red,
  input  logic [CHAN_W-1:0]     left_green,
  input  logic [CHAN_W-1:0]     left_blue,
  input  logic [CHAN_W-1:0]     right_red,
  input  logic [CHAN_W-1:0]     right_green,
  input  logic [CHAN_W-1:0]     right_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [DISP_W-1:0]     disparity,
  output logic [CHAN_W-1:0]     gray,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1024 + 4 * MAX_DISPARITY + 4 * MAX_WINDOW + 16) + 1;
  localparam int RW    = $clog2(MAX_HEIGHT + 1024 + 4 * MAX_WINDOW + 16) + 1;
  localparam int TW    = 6;
  localparam int EW    = DISP_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LMARK, S_RUN, S_WAIT, S_RISSUE, S_RMARK, S_NORM, S_DONE
  } state_t;

  // config registers
  logic [IMG_DIM_W-1:0] image_width, image_height;
  logic [DISP_W-1:0]    disparity_low, disparity_high;
  logic [WIN_W-1:0]     window_size;

  state_t               state;
  logic signed [RW-1:0] r_s;
  logic signed [CW-1:0] c_s;
  logic                 pass;
  logic [EW-1:0]        d;
  logic [DISP_W-1:0]    d1;
  logic [EW-1:0]        ebest;
  logic [SUM_W-1:0]     best, acc;
  logic signed [TW-1:0] ti, tj;
  logic                 v1, v2, okl1, okr1;
  logic [SQ_W-1:0]      sq;
  logic [PIX_W-1:0]     ldata, rdata;
  logic [CHAN_W-1:0]    rem, q, res_gray;
  logic [DISP_W-1:0]    den;
  status_t              res_status;

  logic [PIX_W-1:0] left_mem  [DEPTH];
  logic [PIX_W-1:0] right_mem [DEPTH];

  // effective configuration
  logic signed [CW-1:0] eff_w;
  logic signed [RW-1:0] eff_h;
  logic [DISP_W-1:0]    lo, hi_m, hi;
  logic [WIN_W-1:0]     ws;
  logic signed [TW-1:0] half;

  always_comb begin
    eff_w = CW'((32'(image_width) > MAX_WIDTH) ? MAX_WIDTH : 32'(image_width));
    eff_h = RW'((32'(image_height) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(image_height));
    lo    = DISP_W'((32'(disparity_low) > MAX_DISPARITY) ? MAX_DISPARITY
                                                         : 32'(disparity_low));
    hi_m  = DISP_W'((32'(disparity_high) > MAX_DISPARITY) ? MAX_DISPARITY
                                                          : 32'(disparity_high));
    hi    = (hi_m < lo) ? lo : hi_m;
    ws    = WIN_W'((32'(window_size) > MAX_WINDOW) ? MAX_WINDOW : 32'(window_size));
    half  = TW'(ws >> 1);
  end

  logic accept, load_we;
  logic signed [RW-1:0] in_row_s;
  logic signed [CW-1:0] in_col_s;
  logic [AW-1:0]        waddr;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_row_s = signed'(RW'(row));
  assign in_col_s = signed'(CW'(col));
  assign load_we  = accept && !kind && (in_row_s < eff_h) && (in_col_s < eff_w);
  assign waddr    = AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));

  // tap geometry
  logic signed [CW-1:0] dx, d1x, lbase, rbase, lcol, rcol;
  logic signed [RW-1:0] rd_row;
  logic                 okl, okr;
  logic [AW-1:0]        laddr, raddr;

  always_comb begin
    dx    = signed'(CW'(d));
    d1x   = signed'(CW'(d1));
    lbase = pass ? (c_s + d1x - dx) : c_s;
    rbase = pass ? (c_s + d1x) : (c_s + dx);
    if (state == S_RUN) begin
      rd_row = r_s + RW'(ti);
      lcol   = lbase + CW'(tj);
      rcol   = rbase + CW'(tj);
    end else begin
      rd_row = r_s;
      lcol   = c_s;
      rcol   = c_s + d1x;
    end
    okl   = (rd_row >= 0) && (rd_row < eff_h) && (lcol >= 0) && (lcol < eff_w);
    okr   = (rd_row >= 0) && (rd_row < eff_h) && (rcol >= 0) && (rcol < eff_w);
    laddr = AW'(32'(rd_row) * 32'(MAX_WIDTH) + 32'(lcol));
    raddr = AW'(32'(rd_row) * 32'(MAX_WIDTH) + 32'(rcol));
  end

  always_ff @(posedge clk) begin
    if (load_we) left_mem[waddr] <= pack_pixel(left_red, left_green, left_blue);
    ldata <= left_mem[laddr];
  end

  always_ff @(posedge clk) begin
    if (load_we) right_mem[waddr] <= pack_pixel(right_red, right_green, right_blue);
    rdata <= right_mem[raddr];
  end

  // square unit
  logic signed [CHAN_W+1:0] diff;
  always_comb begin
    diff = signed'(10'(okl1 ? ldata[CHAN_W-1:0] : '0))
         - signed'(10'(okr1 ? rdata[CHAN_W-1:0] : '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
    end
    okl1 <= okl;
    okr1 <= okr;
    sq   <= SQ_W'(diff * diff);
  end

  // compare and next-step decisions
  logic                  take1, take2, tap_last;
  logic [DISP_W-1:0]     nd1;
  logic [EW-1:0]         nebest, d1p3;
  logic signed [EW:0]    lr_diff;

  always_comb begin
    d1p3     = EW'(d1) + EW'(3);
    take1    = (d == EW'(lo)) || (acc < best);
    take2    = (d == d1p3) || (acc < best);
    nd1      = take1 ? DISP_W'(d) : d1;
    nebest   = take2 ? d : ebest;
    lr_diff  = signed'((EW + 1)'(d1)) - signed'((EW + 1)'(nebest));
    tap_last = (ti == half) && (tj == half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      image_width    <= 11'd640;
      image_height   <= 11'd480;
      disparity_low  <= 6'd0;
      disparity_high <= 6'd63;
      window_size    <= 4'd9;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:    image_width    <= cfg_data;
          CFG_IMAGE_HEIGHT:   image_height   <= cfg_data;
          CFG_DISPARITY_LOW:  disparity_low  <= cfg_data[DISP_W-1:0];
          CFG_DISPARITY_HIGH: disparity_high <= cfg_data[DISP_W-1:0];
          CFG_WINDOW_SIZE:    window_size    <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      if (v2) acc <= acc + SUM_W'(sq);

      unique case (state)
        S_IDLE: begin
          if (accept && kind) begin
            r_s   <= in_row_s;
            c_s   <= in_col_s;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if ((r_s >= eff_h) || (c_s >= eff_w)) begin
            res_status <= ST_BLACK;
            state      <= S_DONE;
          end else begin
            state <= S_LMARK;
          end
        end
        S_LMARK: begin
          if (ldata[PIX_W-1]) begin
            res_status <= ST_SKIP;
            state      <= S_DONE;
          end else if (c_s + signed'(CW'(hi)) >= eff_w) begin
            res_status <= ST_BLACK;
            state      <= S_DONE;
          end else begin
            pass  <= 1'b0;
            d     <= EW'(lo);
            ti    <= -half;
            tj    <= -half;
            acc   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tj == half) begin
            tj <= -half;
            ti <= ti + TW'(1);
          end else begin
            tj <= tj + TW'(1);
          end
          if (tap_last) state <= S_WAIT;
        end
        S_WAIT: begin
          if (!v1 && !v2) begin
            ti  <= -half;
            tj  <= -half;
            acc <= '0;
            if (!pass) begin
              if (take1) best <= acc;
              d1 <= nd1;
              if (d == EW'(hi)) begin
                state <= S_RISSUE;
              end else begin
                d     <= d + EW'(1);
                state <= S_RUN;
              end
            end else begin
              if (take2) best <= acc;
              ebest <= nebest;
              if (d == EW'(lo)) begin
                if ((lr_diff >= -2) && (lr_diff <= 2)) begin
                  rem   <= CHAN_MAX;
                  q     <= '0;
                  den   <= hi - lo;
                  state <= S_NORM;
                end else begin
                  res_status <= ST_BLUE;
                  state      <= S_DONE;
                end
              end else begin
                d     <= d - EW'(1);
                state <= S_RUN;
              end
            end
          end
        end
        S_RISSUE: state <= S_RMARK;
        S_RMARK: begin
          if (rdata[PIX_W-1]) begin
            res_status <= ST_SKIP;
            state      <= S_DONE;
          end else if (c_s + CW'(half) < 3) begin
            res_status <= ST_BLUE;
            state      <= S_DONE;
          end else begin
            pass  <= 1'b1;
            d     <= d1p3;
            state <= S_RUN;
          end
        end
        S_NORM: begin
          // 255/(hi-lo) by repeated subtraction
          if ((den != '0) && (rem >= CHAN_W'(den))) begin
            rem <= rem - CHAN_W'(den);
            q   <= q + CHAN_W'(1);
          end else begin
            res_gray   <= CHAN_W'(CHAN_W'(d1 - lo) * q);
            res_status <= ST_VALID;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            disparity <= (res_status == ST_VALID) ? d1 : '0;
            gray      <= (res_status == ST_VALID) ? res_gray : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for stereo_ssd_disparity_lr_check: directed table, then random
// image phases, every compute result checked against a fixed expected match or an in-bench disparity predictor.
// Depends on sdlr_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import sdlr_pkg::*;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;
  localparam int   STORE_W      = 1024;
  localparam int   RANDOM_ITEMS = 290;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  lr, lg, lb, rr, rg, rb;
  } pixel_beat_t;

  typedef struct packed {
    status_t           st;
    logic [DISP_W-1:0] disp;
    logic [CHAN_W-1:0] gray;
  } match_t;

  typedef struct packed {
    pixel_beat_t beat;
    logic        fixed;
    match_t      res;
  } table_row_t;

  logic clk, rst;
  logic in_valid, in_stall, kind;
  logic [COORD_W-1:0] row, col;
  logic [CHAN_W-1:0] left_red, left_green, left_blue, right_red, right_green, right_blue;
  logic out_valid, out_stall;
  logic [STATUS_W-1:0] status;
  logic [DISP_W-1:0] disparity;
  logic [CHAN_W-1:0] gray;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stereo_ssd_disparity_lr_check dut (.*);

  // bench copy of the image memories and registers
  logic [PIX_W-1:0] left_pix [int];
  logic [PIX_W-1:0] right_pix [int];
  int img_w, img_h, disp_lo, disp_hi, win_size;

  match_t pending_matches[$];
  int errors, gap_pct, stall_pct, computes_seen, loads_sent, random_items;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pixel_code(logic [CHAN_W-1:0] r, g, b);
    logic [CHAN_W-1:0] m;
    m = r;
    if (g > m) m = g;
    if (b > m) m = b;
    return {(r == 0 && g == 0 && b == 8'd255), m};
  endfunction

  function automatic int eff_w();
    return img_w > STORE_W ? STORE_W : img_w;
  endfunction

  function automatic int eff_h();
    return img_h > STORE_W ? STORE_W : img_h;
  endfunction

  function automatic int luma(bit right_side, int r, int c);
    if (r < 0 || c < 0 || r >= eff_h() || c >= eff_w()) return 0;
    return right_side ? int'(right_pix[r*STORE_W+c][7:0]) : int'(left_pix[r*STORE_W+c][7:0]);
  endfunction

  function automatic int window_ssd(int r, int cl, int cr, int half);
    int sum, dv;
    sum = 0;
    for (int i = -half; i <= half; i++)
      for (int j = -half; j <= half; j++) begin
        dv = luma(0, r+i, cl+j) - luma(1, r+i, cr+j);
        sum += dv*dv;
      end
    return sum;
  endfunction

  // apply one accepted beat to the bench image copy; returns 1 with the match for a compute
  function automatic bit predict_disparity(pixel_beat_t b, output match_t m);
    int lo, hi, half, norm, r, c, d1, d2, best, s, diff;
    m = '0;
    r = int'(b.row);
    c = int'(b.col);
    if (b.kind == KIND_LOAD) begin
      if (r < eff_h() && c < eff_w()) begin
        left_pix[r*STORE_W+c]  = pixel_code(b.lr, b.lg, b.lb);
        right_pix[r*STORE_W+c] = pixel_code(b.rr, b.rg, b.rb);
      end
      return 0;
    end
    lo = disp_lo;
    hi = disp_hi < lo ? lo : disp_hi;
    half = win_size / 2;
    norm = hi > lo ? 255 / (hi - lo) : 0;
    d1 = 0;
    d2 = 0;
    best = 0;
    if (r >= eff_h() || c >= eff_w()) m.st = ST_BLACK;
    else if (left_pix[r*STORE_W+c][8]) m.st = ST_SKIP;
    else if (c + hi >= eff_w()) m.st = ST_BLACK;
    else begin
      for (int d = lo; d <= hi; d++) begin
        s = window_ssd(r, c, c+d, half);
        if (d == lo || s < best) begin
          best = s;
          d1 = d;
        end
      end
      if (right_pix[r*STORE_W+c+d1][8]) m.st = ST_SKIP;
      else if (c + half < 3) m.st = ST_BLUE;
      else begin
        for (int d = -(d1+3); d <= -lo; d++) begin
          s = window_ssd(r, c+d1+d, c+d1, half);
          if (d == -(d1+3) || s < best) begin
            best = s;
            d2 = d;
          end
        end
        diff = d1 + d2;
        if (diff < 0) diff = -diff;
        if (diff <= 2) begin
          m.st = ST_VALID;
          m.disp = DISP_W'(d1);
          m.gray = CHAN_W'((d1 - lo) * norm);
        end else m.st = ST_BLUE;
      end
    end
    return 1;
  endfunction

  task automatic send_beat(pixel_beat_t b, bit fixed, match_t fixed_res);
    match_t m;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    kind <= b.kind;
    row <= b.row;
    col <= b.col;
    left_red <= b.lr;
    left_green <= b.lg;
    left_blue <= b.lb;
    right_red <= b.rr;
    right_green <= b.rg;
    right_blue <= b.rb;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_disparity(b, m)) pending_matches.push_back(fixed ? fixed_res : m);
    if (b.kind == KIND_LOAD) loads_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int w, int h, int lo, int hi, int ws);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;    cfg_data <= CFG_DATA_W'(w);  @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;   cfg_data <= CFG_DATA_W'(h);  @(posedge clk);
    cfg_index <= CFG_DISPARITY_LOW;  cfg_data <= CFG_DATA_W'(lo); @(posedge clk);
    cfg_index <= CFG_DISPARITY_HIGH; cfg_data <= CFG_DATA_W'(hi); @(posedge clk);
    cfg_index <= CFG_WINDOW_SIZE;    cfg_data <= CFG_DATA_W'(ws); @(posedge clk);
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
    disp_lo = lo;
    disp_hi = hi;
    win_size = ws;
  endtask

  function automatic pixel_beat_t mk(logic k, int r, int c, int lr = 0, int lg = 0,
                                     int lb = 0, int rr = 0, int rg = 0, int rb = 0);
    pixel_beat_t b;
    b = '{k, COORD_W'(r), COORD_W'(c), CHAN_W'(lr), CHAN_W'(lg), CHAN_W'(lb),
          CHAN_W'(rr), CHAN_W'(rg), CHAN_W'(rb)};
    return b;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      computes_seen++;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result status=%0d disparity=%0d gray=%0d",
                 $time, status, disparity, gray);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, status);
          errors++;
        end
        if (disparity !== want.disp) begin
          $display("%0t: disparity expected %0d got %0d", $time, want.disp, disparity);
          errors++;
        end
        if (gray !== want.gray) begin
          $display("%0t: gray expected %0d got %0d", $time, want.gray, gray);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    table_row_t dir_rows[$];
    match_t blk, skp, none;
    logic [CHAN_W-1:0] lum [0:3][0:31];
    logic [CHAN_W-1:0] rlum [0:3][0:31];
    bit lmark [0:3][0:31];
    int w, h, lo, hi, ws, shift, hi_e, n, r, c;
    pixel_beat_t b;

    errors = 0; computes_seen = 0; loads_sent = 0; random_items = 0;
    gap_pct = 18; stall_pct = 72;
    rst = 1'b1; in_valid = 1'b0; kind = KIND_LOAD; row = '0; col = '0;
    left_red = '0; left_green = '0; left_blue = '0;
    right_red = '0; right_green = '0; right_blue = '0;
    out_stall = 1'b0; cfg_we = 1'b0; cfg_index = CFG_IMAGE_WIDTH; cfg_data = '0;
    img_w = 640; img_h = 480; disp_lo = 0; disp_hi = 63; win_size = 9;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    blk = '{ST_BLACK, 6'd0, 8'd0};
    skp = '{ST_SKIP, 6'd0, 8'd0};
    none = '0;
    // reset registers: row 479 is the last one, 480 is off the image
    send_beat(mk(KIND_COMPUTE, 480, 5), 1'b1, blk);
    drain();

    // tiny one-row image; left-edge, marks and right-edge cases
    dir_rows = '{
      '{mk(KIND_LOAD, 0, 0, 0, 0, 0, 255, 255, 255), 1'b0, none},
      '{mk(KIND_LOAD, 0, 1, 0, 0, 255, 10, 20, 30), 1'b0, none},
      '{mk(KIND_LOAD, 0, 2, 255, 255, 255, 0, 0, 255), 1'b0, none},
      '{mk(KIND_LOAD, 0, 3, 200, 5, 7, 255, 0, 0), 1'b0, none},
      '{mk(KIND_LOAD, 0, 4, 9, 100, 3, 200, 1, 1), 1'b0, none},
      '{mk(KIND_LOAD, 0, 5, 60, 60, 60, 100, 0, 100), 1'b0, none},
      '{mk(KIND_LOAD, 1, 0, 1, 2, 3, 4, 5, 6), 1'b0, none},
      '{mk(KIND_COMPUTE, 0, 1), 1'b1, skp},
      '{mk(KIND_COMPUTE, 0, 5), 1'b1, blk},
      '{mk(KIND_COMPUTE, 5, 0), 1'b1, blk},
      '{mk(KIND_COMPUTE, 1023, 1023), 1'b1, blk},
      '{mk(KIND_COMPUTE, 0, 0), 1'b0, none},
      '{mk(KIND_COMPUTE, 0, 2), 1'b0, none},
      '{mk(KIND_COMPUTE, 0, 3), 1'b0, none},
      '{mk(KIND_COMPUTE, 0, 4), 1'b0, none},
      '{mk(KIND_LOAD, 1023, 1023, 17, 34, 51, 68, 85, 102), 1'b0, none},
      '{mk(KIND_COMPUTE, 1023, 1023), 1'b1, blk}
    };
    set_config(6, 1, 0, 1, 3);
    foreach (dir_rows[i]) begin
      if (i == 15) begin
        drain();
        // oversize registers are capped at the memory limits
        set_config(2047, 2047, 62, 63, 15);
      end
      send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].res);
    end
    drain();

    // random phases: shifted stereo pairs loaded in full, then computes
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS/3) begin
        gap_pct = 18; stall_pct = 72;
      end else if (random_items < 2*RANDOM_ITEMS/3) begin
        gap_pct = 72; stall_pct = 18;
      end else begin
        gap_pct = 0; stall_pct = 0;
      end
      lo = $urandom_range(0, 3);
      hi = ($urandom_range(5) == 0) ? $urandom_range(0, lo) : lo + $urandom_range(1, 6);
      ws = $urandom_range(0, 3) * 2 + 1;
      if ($urandom_range(7) == 0) begin
        ws = $urandom_range(0, 15);
        if (ws > 7) hi = lo + $urandom_range(0, 1);
      end
      hi_e = hi < lo ? lo : hi;
      w = $urandom_range(6, 14);
      if (w < hi_e + 4) w = hi_e + 4;
      h = $urandom_range(1, 4);
      shift = $urandom_range(lo, hi_e);
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          lum[y][x] = CHAN_W'($urandom_range(0, 255));
          lmark[y][x] = ($urandom_range(19) == 0);
          rlum[y][x] = (x >= shift && $urandom_range(9) != 0) ? lum[y][x-shift]
                                                             : CHAN_W'($urandom_range(0, 255));
        end
      drain();
      set_config(w, h, lo, hi, ws);
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          b = mk(KIND_LOAD, y, x, $urandom_range(0, 255), $urandom_range(0, 255), lum[y][x],
                 $urandom_range(0, 255), $urandom_range(0, 255), rlum[y][x]);
          // intensity is the max channel: keep the others at or below it
          b.lr = CHAN_W'(int'(b.lr) % (int'(lum[y][x]) + 1));
          b.lg = CHAN_W'(int'(b.lg) % (int'(lum[y][x]) + 1));
          b.rr = CHAN_W'(int'(b.rr) % (int'(rlum[y][x]) + 1));
          b.rg = CHAN_W'(int'(b.rg) % (int'(rlum[y][x]) + 1));
          if (lmark[y][x]) begin
            b.lr = 0; b.lg = 0; b.lb = 255;
          end
          if ($urandom_range(24) == 0) begin
            b.rr = 0; b.rg = 0; b.rb = 255;
          end
          send_beat(b, 1'b0, none);
          random_items++;
          if ($urandom_range(7) == 0) begin
            send_beat(mk(KIND_LOAD, $urandom_range(h, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)),
                      1'b0, none);
            random_items++;
          end
        end
      n = $urandom_range(12, 22);
      repeat (n) begin
        r = $urandom_range(0, h - 1);
        c = $urandom_range(0, w - hi_e - 1);
        case ($urandom_range(9))
          0: c = $urandom_range(0, w - 1);
          1: begin
            r = $urandom_range(0, 1023);
            c = $urandom_range(0, 1023);
          end
          default: ;
        endcase
        send_beat(mk(KIND_COMPUTE, r, c), 1'b0, none);
        random_items++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (pending_matches.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_matches.size());
      errors++;
    end
    $display("Covered %0d load beats and %0d disparity results over several image setups,",
             loads_sent, computes_seen);
    $display("with sender and receiver idling swapped and then removed; %0d mismatches", errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
